[sv/kph_pkg.sv]
// ----------------------------------------------------------------------------
// kph_pkg
// Shared constants and types for the keyed permutation hash core.
// ----------------------------------------------------------------------------
package kph_pkg;

    // Default sizes
    localparam int KEY_STORE_DEPTH_DEF = 256;
    localparam int DIGEST_BYTES_DEF    = 32;

    // Fixed geometry of the permutation table and words
    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = 8;
    localparam int BYTE_W      = 8;
    localparam int INDEX_W     = 5;

    // Controller states, one-hot
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INIT    = 9'b000000010,
        S_RD_I    = 9'b000000100,
        S_RD_SEL  = 9'b000001000,
        S_WR_I    = 9'b000010000,
        S_WR_SEL  = 9'b000100000,
        S_D_START = 9'b001000000,
        S_D_STEP  = 9'b010000000,
        S_D_EMIT  = 9'b100000000
    } state_t;

endpackage

[sv/kph_ram.sv]
// ----------------------------------------------------------------------------
// kph_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[sv/keyed_permutation_hash_256_core.sv]
// ----------------------------------------------------------------------------
// keyed_permutation_hash_256_core
// Keyed byte-permutation digest with an RC4-style table shuffle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one key word per cycle:
//   key_byte plus last_byte. The first KEY_STORE_DEPTH bytes of a key are
//   kept in the key RAM; later bytes are dropped. The word with last_byte
//   set closes the key and starts the hash; in_stall stays high until the
//   whole digest has been handed to the output register.
//   Output channel (out_valid / out_stall) gives DIGEST_BYTES words:
//   hash_byte, byte_index (position mod 32) and last_out on the final one.
// Timing:
//   Key bytes: one per cycle while the core is idle. After the last byte,
//   the table is filled with the identity, then the shuffle handles each
//   entry in turn (read entry, read partner, two write-backs through the
//   single-write-port table RAM), then a setup state and, per digest byte,
//   a step state and an emit state (chained table reads); the emit state
//   waits while the receiver stalls.
// Reset clears state, key count and out_valid; the data registers and
// RAM are not cleared. A stalled output word holds, the digest walk waits.
// ----------------------------------------------------------------------------
module keyed_permutation_hash_256_core #(
    parameter int KEY_STORE_DEPTH = kph_pkg::KEY_STORE_DEPTH_DEF,
    parameter int DIGEST_BYTES    = kph_pkg::DIGEST_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [kph_pkg::BYTE_W-1:0]  key_byte,
    input  logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [kph_pkg::BYTE_W-1:0]  hash_byte,
    output logic [kph_pkg::INDEX_W-1:0] byte_index,
    output logic                        last_out
);

    localparam int KW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
    localparam int CW = $clog2(KEY_STORE_DEPTH + 1);
    localparam int TW = kph_pkg::TABLE_AW;
    localparam int BW = kph_pkg::BYTE_W;

    kph_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [KW-1:0] kidx_reg, kidx_next;
    logic [TW-1:0] idx_reg, idx_next;
    logic [TW-1:0] k_reg, k_next;
    logic [TW-1:0] j_reg, j_next;
    logic [TW-1:0] sel_reg, sel_next;
    logic [BW-1:0] a_reg, a_next;

    logic          out_valid_reg, out_valid_next;
    logic [BW-1:0] hash_reg, hash_next;
    logic [kph_pkg::INDEX_W-1:0] bidx_reg, bidx_next;
    logic          lastout_reg, lastout_next;

    logic          in_acc;
    logic          out_free;
    logic [TW-1:0] sel_comb;
    logic [TW-1:0] jstep_comb;

    // Key RAM ports
    logic          key_we;
    logic [KW-1:0] key_wa;
    logic [BW-1:0] key_rd;

    // Table RAM ports
    logic          tab_we;
    logic [TW-1:0] tab_wa;
    logic [BW-1:0] tab_wd;
    logic [TW-1:0] tab_ra;
    logic [BW-1:0] tab_rd;

    kph_ram #(.WIDTH(BW), .DEPTH(KEY_STORE_DEPTH), .AW(KW)) u_key_ram (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (key_wa),
        .wr_data (key_byte),
        .rd_addr (kidx_reg),
        .rd_data (key_rd)
    );

    kph_ram #(.WIDTH(BW), .DEPTH(kph_pkg::TABLE_DEPTH), .AW(TW)) u_tab_ram (
        .clk     (clk),
        .wr_en   (tab_we),
        .wr_addr (tab_wa),
        .wr_data (tab_wd),
        .rd_addr (tab_ra),
        .rd_data (tab_rd)
    );

    // Handshake helpers
    assign in_stall = (state_reg != kph_pkg::S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Partner index and chained digest index
    assign sel_comb   = tab_rd + key_rd;
    assign jstep_comb = tab_rd + k_reg;

    // Key store write: only while below depth
    assign key_we = in_acc && (count_reg < CW'(KEY_STORE_DEPTH));
    assign key_wa = count_reg[KW-1:0];

    // Table RAM port muxing
    always_comb
    begin
        tab_we = 1'b0;
        tab_wa = idx_reg;
        tab_wd = idx_reg;
        tab_ra = j_reg;
        unique case (state_reg)
            kph_pkg::S_INIT:
            begin
                tab_we = 1'b1;
            end
            kph_pkg::S_RD_I:
            begin
                tab_ra = idx_reg;
            end
            kph_pkg::S_RD_SEL:
            begin
                tab_ra = sel_comb;
            end
            kph_pkg::S_WR_I:
            begin
                tab_we = 1'b1;
                tab_wd = tab_rd;
            end
            kph_pkg::S_WR_SEL:
            begin
                tab_we = 1'b1;
                tab_wa = sel_reg;
                tab_wd = a_reg;
            end
            kph_pkg::S_D_STEP:
            begin
                tab_ra = jstep_comb;
            end
            default:
            begin
                tab_ra = j_reg;
            end
        endcase
    end

    // Controller
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        kidx_next      = kidx_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        sel_next       = sel_reg;
        a_next         = a_reg;
        out_valid_next = out_valid_reg && out_stall;
        hash_next      = hash_reg;
        bidx_next      = bidx_reg;
        lastout_next   = lastout_reg;

        unique case (state_reg)
            kph_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (key_we)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (last_byte)
                    begin
                        idx_next   = '0;
                        state_next = kph_pkg::S_INIT;
                    end
                end
            end
            kph_pkg::S_INIT:
            begin
                idx_next = idx_reg + TW'(1);
                if (idx_reg == '1)
                begin
                    kidx_next  = '0;
                    state_next = kph_pkg::S_RD_I;
                end
            end
            kph_pkg::S_RD_I:
            begin
                state_next = kph_pkg::S_RD_SEL;
            end
            kph_pkg::S_RD_SEL:
            begin
                a_next     = tab_rd;
                sel_next   = sel_comb;
                state_next = kph_pkg::S_WR_I;
            end
            kph_pkg::S_WR_I:
            begin
                state_next = kph_pkg::S_WR_SEL;
            end
            kph_pkg::S_WR_SEL:
            begin
                // key index runs i mod len
                if (CW'(kidx_reg) + CW'(1) == count_reg)
                begin
                    kidx_next = '0;
                end
                else
                begin
                    kidx_next = kidx_reg + KW'(1);
                end
                idx_next = idx_reg + TW'(1);
                if (idx_reg == '1)
                begin
                    j_next     = '0;
                    k_next     = '0;
                    state_next = kph_pkg::S_D_START;
                end
                else
                begin
                    state_next = kph_pkg::S_RD_I;
                end
            end
            kph_pkg::S_D_START:
            begin
                state_next = kph_pkg::S_D_STEP;
            end
            kph_pkg::S_D_STEP:
            begin
                j_next     = jstep_comb;
                state_next = kph_pkg::S_D_EMIT;
            end
            kph_pkg::S_D_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hash_next      = tab_rd;
                    bidx_next      = k_reg[kph_pkg::INDEX_W-1:0];
                    lastout_next   = (k_reg == TW'(DIGEST_BYTES - 1));
                    k_next         = k_reg + TW'(1);
                    if (k_reg == TW'(DIGEST_BYTES - 1))
                    begin
                        count_next = '0;
                        state_next = kph_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = kph_pkg::S_D_STEP;
                    end
                end
            end
            default:
            begin
                state_next = kph_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kph_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        kidx_reg    <= kidx_next;
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        j_reg       <= j_next;
        sel_reg     <= sel_next;
        a_reg       <= a_next;
        hash_reg    <= hash_next;
        bidx_reg    <= bidx_next;
        lastout_reg <= lastout_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_byte  = hash_reg;
    assign byte_index = bidx_reg;
    assign last_out   = lastout_reg;

endmodule

[sv/kph_checker.sv]
// ----------------------------------------------------------------------------
// kph_checker
// Port-level assertions for the keyed permutation hash core.
// ----------------------------------------------------------------------------
module kph_checker #(
    parameter int DIGEST_BYTES = kph_pkg::DIGEST_BYTES_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        last_byte,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [kph_pkg::BYTE_W-1:0]  hash_byte,
    input logic [kph_pkg::INDEX_W-1:0] byte_index,
    input logic                        last_out
);

    // Closing a key makes the core busy next cycle
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_byte |=> in_stall)
        else $error("core not busy after last key word");

    // While taking key words only the final digest word may be pending
    a_idle_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && out_valid |-> last_out)
        else $error("digest word pending while accepting key");

    // Final digest word carries the right position
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_out |->
            byte_index == kph_pkg::INDEX_W'(DIGEST_BYTES - 1))
        else $error("last digest word has wrong index");

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hash_byte)
            && $stable(byte_index) && $stable(last_out))
        else $error("stalled output word changed");

endmodule

bind keyed_permutation_hash_256_core kph_checker #(
    .DIGEST_BYTES (DIGEST_BYTES)
) u_kph_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_byte  (hash_byte),
    .byte_index (byte_index),
    .last_out   (last_out)
);

[tb/sv/keyed_permutation_hash_256_core_tb.sv]
// ----------------------------------------------------------------------------
// keyed_permutation_hash_256_core_tb
// Self-checking bench for the keyed permutation hash core. Key words are fed
// on the input channel with random gaps. The receiver applies random stall.
// An in-bench predictor rebuilds the shuffled table for every key and queues
// the digest words that the core should give. A short directed table covers
// the all-zero key (identity table), extreme byte values and short keys.
// Random keys of mixed length follow.
// ----------------------------------------------------------------------------
module keyed_permutation_hash_256_core_tb;

    localparam int KEY_DEPTH    = kph_pkg::KEY_STORE_DEPTH_DEF;
    localparam int DIGEST_LEN   = kph_pkg::DIGEST_BYTES_DEF;
    localparam int RANDOM_ITEMS = 140;
    localparam int DIRECTED_LEN = 17;
    localparam int TAIL_CYCLES  = 40;
    localparam int RUN_LIMIT    = 12000000;

    // One row of the directed table; typed_digest selects the hand-typed
    // digest of an all-zero key instead of the predictor
    typedef struct packed {
        logic [kph_pkg::BYTE_W-1:0] key_val;
        logic                       is_last;
        logic                       typed_digest;
    } key_row_t;

    typedef struct packed {
        logic [kph_pkg::BYTE_W-1:0]  hash;
        logic [kph_pkg::INDEX_W-1:0] idx;
        logic                        last;
    } digest_word_t;

    localparam key_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{8'h00, 1'b1, 1'b1},   // single zero byte right after reset
        '{8'hFF, 1'b1, 1'b0},   // single 0xFF byte
        '{8'h00, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0},
        '{8'h00, 1'b1, 1'b1},   // three zero bytes: still the identity table
        '{8'hFF, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0},
        '{8'hFF, 1'b0, 1'b0},
        '{8'h00, 1'b1, 1'b0},
        '{8'hA5, 1'b0, 1'b0},
        '{8'h5A, 1'b0, 1'b0},
        '{8'h01, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b0},
        '{8'h7F, 1'b0, 1'b0},
        '{8'hFE, 1'b1, 1'b0},
        '{8'h01, 1'b0, 1'b0},
        '{8'h02, 1'b1, 1'b0}
    };

    // All-zero key leaves the table at identity, so the chained index walks
    // the triangular numbers mod 256
    localparam logic [kph_pkg::BYTE_W-1:0] ZERO_KEY_DIGEST [32] = '{
        8'd0,   8'd1,   8'd3,   8'd6,   8'd10,  8'd15,  8'd21,  8'd28,
        8'd36,  8'd45,  8'd55,  8'd66,  8'd78,  8'd91,  8'd105, 8'd120,
        8'd136, 8'd153, 8'd171, 8'd190, 8'd210, 8'd231, 8'd253, 8'd20,
        8'd44,  8'd69,  8'd95,  8'd122, 8'd150, 8'd179, 8'd209, 8'd240
    };

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [kph_pkg::BYTE_W-1:0]   key_byte;
    logic                         last_byte;
    logic                         out_valid;
    logic                         out_stall;
    logic [kph_pkg::BYTE_W-1:0]   hash_byte;
    logic [kph_pkg::INDEX_W-1:0]  byte_index;
    logic                         last_out;

    // Predictor state
    logic [kph_pkg::BYTE_W-1:0]   key_mem [kph_pkg::TABLE_DEPTH];
    logic [kph_pkg::BYTE_W-1:0]   perm [kph_pkg::TABLE_DEPTH];
    int                           key_count;
    digest_word_t                 pending_digest [$];

    int                           mismatch_count = 0;
    bit                           lazy_in;
    bit                           lazy_out;

    keyed_permutation_hash_256_core #(
        .KEY_STORE_DEPTH (KEY_DEPTH),
        .DIGEST_BYTES    (DIGEST_LEN)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_byte   (key_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_byte  (hash_byte),
        .byte_index (byte_index),
        .last_out   (last_out)
    );

    always #4 clk = ~clk;

    // Store one key word; on the last word shuffle the table and queue
    // the digest it produces
    task automatic absorb_key_word(input logic [kph_pkg::BYTE_W-1:0] kb, input logic lb,
                                   input logic typed);
        int                         len;
        logic [kph_pkg::BYTE_W-1:0] sel;
        logic [kph_pkg::BYTE_W-1:0] tmp;
        logic [kph_pkg::BYTE_W-1:0] j;
        digest_word_t               w;
        if (key_count < KEY_DEPTH)
        begin
            key_mem[key_count] = kb;
            key_count++;
        end
        if (lb)
        begin
            len = key_count;
            for (int i = 0; i < kph_pkg::TABLE_DEPTH; i++)
                perm[i] = i[kph_pkg::BYTE_W-1:0];
            for (int i = 0; i < kph_pkg::TABLE_DEPTH; i++)
            begin
                sel       = perm[i] + key_mem[i % len];
                tmp       = perm[i];
                perm[i]   = perm[sel];
                perm[sel] = tmp;
            end
            j = '0;
            for (int k = 0; k < DIGEST_LEN; k++)
            begin
                j      = perm[j] + k[kph_pkg::BYTE_W-1:0];
                w.hash = typed ? ZERO_KEY_DIGEST[k] : perm[j];
                w.idx  = k[kph_pkg::INDEX_W-1:0];
                w.last = (k == DIGEST_LEN - 1);
                pending_digest.push_back(w);
            end
            key_count = 0;
        end
    endtask

    // Drive one key word after a random gap and wait until it is taken
    task automatic send_key_word(input logic [kph_pkg::BYTE_W-1:0] kb, input logic lb,
                                 input logic typed);
        int gap;
        if ($urandom_range(0, 15) == 0)
            lazy_in = !lazy_in;
        gap = lazy_in ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        key_byte  <= kb;
        last_byte <= lb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb_key_word(kb, lb, typed);
    endtask

    // Hold off the sender until the whole digest has come out
    task automatic drain_digest();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_digest.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [kph_pkg::BYTE_W-1:0] rand_key_val();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Compare one accepted digest word with the oldest expectation
    task automatic check_digest_word();
        digest_word_t want;
        if (pending_digest.size() == 0)
        begin
            if (mismatch_count < 10)
                $display("unexpected word: hash_byte=%02h byte_index=%0d last_out=%0b",
                         hash_byte, byte_index, last_out);
            mismatch_count++;
        end
        else
        begin
            want = pending_digest.pop_front();
            if (hash_byte !== want.hash || byte_index !== want.idx ||
                last_out !== want.last)
            begin
                if (mismatch_count < 10)
                    $display("digest mismatch: hash %02h/%02h idx %0d/%0d last %0b/%0b (exp/act)",
                             want.hash, hash_byte, want.idx, byte_index,
                             want.last, last_out);
                mismatch_count++;
            end
        end
    endtask

    // Receiver: random stall per word, check on every accepted word
    initial
    begin
        int hold;
        out_stall = 1'b0;
        lazy_out  = 1'b1;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                lazy_out = !lazy_out;
            hold = lazy_out ? $urandom_range(0, 10) : 0;
            if (hold > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            check_digest_word();
        end
    end

    // Stimulus and end of run
    initial
    begin
        int items_sent;
        int len;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        key_byte       = '0;
        last_byte      = 1'b0;
        key_count      = 0;
        lazy_in        = 1'b0;
        items_sent     = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (DIRECTED_ROWS[r])
            send_key_word(DIRECTED_ROWS[r].key_val, DIRECTED_ROWS[r].is_last,
                          DIRECTED_ROWS[r].typed_digest);
        drain_digest();

        // Random keys, mostly short
        while (items_sent < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                              : $urandom_range(1, 12);
            for (int n = 0; n < len; n++)
                send_key_word(rand_key_val(), n == len - 1, 1'b0);
            items_sent += len;
            if ($urandom_range(0, 9) == 0)
                drain_digest();
        end

        drain_digest();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_digest.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("Verification failed");
        $finish;
    end

endmodule
